FILE: src/fje_pkg.sv
// Shared types and constants for the flash job emulator.
`default_nettype none

package fje_pkg;

   // Field widths of the request and response items
   localparam int OFF_W  = 15;
   localparam int LEN_W  = 15;
   localparam int IDX_W  = 14;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 32;
   localparam int LAT_W  = 8;

   // Value of an erased flash byte
   localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

   // Reset value of the latency register
   localparam logic [LAT_W-1:0] LAT_RESET = 8'd1;

   typedef enum logic [2:0] {
      OP_INIT  = 3'd0,
      OP_READ  = 3'd1,
      OP_WRITE = 3'd2,
      OP_ERASE = 3'd3,
      OP_STAGE = 3'd4,
      OP_TICK  = 3'd5,
      OP_FETCH = 3'd6,
      OP_NOP   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_UNINIT = 2'd0,
      ST_IDLE   = 2'd1,
      ST_BUSY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RES_OK      = 2'd0,
      RES_FAILED  = 2'd1,
      RES_PENDING = 2'd2
   } result_type;

   // Job kinds run by the memory walker; fill is the first-init sweep
   typedef enum logic [1:0] {
      JOB_FILL  = 2'd0,
      JOB_READ  = 2'd1,
      JOB_WRITE = 2'd2,
      JOB_ERASE = 2'd3
   } job_kind_type;

   typedef struct packed {
      op_type              op;
      logic [OFF_W-1:0]    offset;
      logic [LEN_W-1:0]    length;
      logic [IDX_W-1:0]    buf_index;
      logic [BYTE_W-1:0]   data_byte;
   } req_type;

   typedef struct packed {
      logic                accepted;
      status_type          status;
      result_type          job_result;
      logic [BYTE_W-1:0]   read_byte;
      logic [CNT_W-1:0]    violation_count;
      logic [CNT_W-1:0]    out_of_range_count;
      logic [CNT_W-1:0]    rejected_count;
   } rsp_type;

   // Job start command from the controller to the walker
   typedef struct packed {
      job_kind_type        kind;
      logic [OFF_W-1:0]    offset;
      logic [LEN_W-1:0]    length;
   } job_cmd_type;

   // Job completion status from the walker
   typedef struct packed {
      logic                done;
      logic                fail;
   } job_stat_type;

endpackage

`default_nettype wire

FILE: src/fje_engine.sv
// Flash and job buffer memories with the job walker that runs read, write, erase and fill.
`default_nettype none

module fje_engine import fje_pkg::*; #(
   parameter int MEM_BYTES = 16384,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire job_cmd_type       cmd,
   output job_stat_type           stat,
   input  wire logic              host_we,
   input  wire logic [AW-1:0]     host_waddr,
   input  wire logic [BYTE_W-1:0] host_wdata,
   input  wire logic [AW-1:0]     host_raddr,
   output logic [BYTE_W-1:0]      host_rdata
);

   // Count width: must hold MEM_BYTES itself and any request field
   localparam int CLW = $clog2(MEM_BYTES + 1);
   localparam int RW  = (CLW > OFF_W) ? CLW : OFF_W;
   localparam logic [RW-1:0] MEM_EXT = RW'(MEM_BYTES);

   typedef enum logic [2:0] {
      E_IDLE  = 3'b001,
      E_CHECK = 3'b010,
      E_COPY  = 3'b100
   } eng_state_type;

   eng_state_type     state_ff, state_in;
   logic [RW-1:0]     idx_ff, idx_in;
   logic              p_vld_ff, p_vld_in;
   logic [RW-1:0]     p_idx_ff;
   job_kind_type      kind_ff, kind_in;
   logic [RW-1:0]     off_ff, off_in;
   logic [RW-1:0]     end_ff, end_in;

   logic [BYTE_W-1:0] flash_mem [MEM_BYTES];
   logic [BYTE_W-1:0] buf_mem   [MEM_BYTES];
   logic [BYTE_W-1:0] flash_q_ff;
   logic [BYTE_W-1:0] buf_q_ff;

   logic              issue;
   logic              last_done;
   logic              mismatch;
   logic              copy_wr;
   logic [AW-1:0]     flash_raddr;
   logic [AW-1:0]     buf_raddr;
   logic              flash_we;
   logic [AW-1:0]     flash_waddr;
   logic [BYTE_W-1:0] flash_wdata;
   logic              buf_we;
   logic [AW-1:0]     buf_waddr;
   logic [BYTE_W-1:0] buf_wdata;

   // Address issue and pipeline status
   assign issue       = (state_ff != E_IDLE) && (idx_ff != end_ff);
   assign last_done   = !p_vld_ff && (idx_ff == end_ff);
   assign mismatch    = p_vld_ff && ((flash_q_ff & buf_q_ff) != buf_q_ff);
   assign copy_wr     = (state_ff == E_COPY) && p_vld_ff;
   assign flash_raddr = AW'(off_ff + idx_ff);
   assign buf_raddr   = (state_ff == E_IDLE) ? host_raddr : AW'(idx_ff);
   assign host_rdata  = buf_q_ff;

   // Write-back stage, in the cycle after the read
   assign flash_we    = copy_wr && (kind_ff != JOB_READ);
   assign flash_waddr = AW'(off_ff + p_idx_ff);
   assign flash_wdata = (kind_ff == JOB_WRITE) ? buf_q_ff : ERASED_BYTE;
   assign buf_we      = host_we || (copy_wr && (kind_ff == JOB_READ));
   assign buf_waddr   = host_we ? host_waddr : AW'(p_idx_ff);
   assign buf_wdata   = host_we ? host_wdata : flash_q_ff;

   // Walker sequencing
   always_comb begin
      state_in  = state_ff;
      idx_in    = issue ? RW'(idx_ff + RW'(1)) : idx_ff;
      p_vld_in  = issue;
      kind_in   = kind_ff;
      off_in    = off_ff;
      end_in    = end_ff;
      stat.done = 1'b0;
      stat.fail = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd_valid) begin
               kind_in = cmd.kind;
               idx_in  = '0;
               if (cmd.kind == JOB_FILL) begin
                  off_in = '0;
                  end_in = MEM_EXT;
               end else begin
                  off_in = RW'(cmd.offset);
                  end_in = RW'(cmd.length);
               end
               state_in = (cmd.kind == JOB_WRITE) ? E_CHECK : E_COPY;
            end
         end
         E_CHECK: begin
            // any 0-to-1 bit aborts the write before flash is touched
            if (mismatch) begin
               stat.done = 1'b1;
               stat.fail = 1'b1;
               p_vld_in  = 1'b0;
               state_in  = E_IDLE;
            end else if (last_done) begin
               idx_in   = '0;
               state_in = E_COPY;
            end
         end
         E_COPY: begin
            if (last_done) begin
               stat.done = 1'b1;
               state_in  = E_IDLE;
            end
         end
         default: begin
            p_vld_in = 1'b0;
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         p_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_vld_ff <= p_vld_in;
      end
      idx_ff   <= idx_in;
      p_idx_ff <= idx_ff;
      kind_ff  <= kind_in;
      off_ff   <= off_in;
      end_ff   <= end_in;
   end

   // Flash array
   always_ff @(posedge clock) begin
      if (flash_we) begin
         flash_mem[flash_waddr] <= flash_wdata;
      end
      flash_q_ff <= flash_mem[flash_raddr];
   end

   // Job buffer array
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_q_ff <= buf_mem[buf_raddr];
   end

endmodule

`default_nettype wire

FILE: src/flash_job_emulator_top.sv
// Top level of the flash job emulator: command decode, job state, counters and result register.
// An accepted item is held in the command register and decoded in the execute state; no new
// item is taken until its result is loaded into the output register. A stalled result in the
// output register holds the next item's result back. A tick that runs a job adds a memory
// walk, one byte per cycle: read or erase one pass, write a verify pass, then a program pass.
// Synchronous reset clears control state; the first init adds a fill sweep of the whole flash.
`default_nettype none

module flash_job_emulator_top import fje_pkg::*; #(
   parameter int MEM_BYTES    = 16384,
   parameter int SECTOR_BYTES = 8192
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [LAT_W-1:0] csr_data
);

   localparam int AW  = $clog2(MEM_BYTES);
   localparam int CLW = $clog2(MEM_BYTES + 1);
   localparam int RW  = (CLW > OFF_W) ? CLW : OFF_W;
   localparam logic [RW-1:0] MEM_EXT  = RW'(MEM_BYTES);
   // sector size must be a power of two; the block does not check it
   localparam logic [RW-1:0] SEC_MASK = RW'(SECTOR_BYTES - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_RUN  = 4'b0100,
      S_OUT  = 4'b1000
   } top_state_type;

   top_state_type     state_ff, state_in;
   req_type           cmd_ff;
   logic [LAT_W-1:0]  lat_ff;
   status_type        status_ff, status_in;
   result_type        result_ff, result_in;
   job_kind_type      kind_ff, kind_in;
   logic [OFF_W-1:0]  joff_ff, joff_in;
   logic [LEN_W-1:0]  jlen_ff, jlen_in;
   logic [LAT_W-1:0]  ticks_ff, ticks_in;
   logic [CNT_W-1:0]  viol_ff, viol_in;
   logic [CNT_W-1:0]  range_ff, range_in;
   logic [CNT_W-1:0]  rej_ff, rej_in;
   logic              acc_ff, acc_in;
   logic [BYTE_W-1:0] rb_ff, rb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              slot_free;
   logic              load;
   logic              eng_start;
   job_cmd_type       eng_cmd;
   job_stat_type      eng_stat;
   logic              stage_we;
   logic [BYTE_W-1:0] buf_rdata;
   logic [RW-1:0]     off_ext;
   logic [RW-1:0]     len_ext;
   logic              idx_ok;
   logic              out_of_range;
   logic              misaligned;
   logic [LAT_W-1:0]  ticks_dec;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Request checks on the held item
   assign off_ext      = RW'(cmd_ff.offset);
   assign len_ext      = RW'(cmd_ff.length);
   assign idx_ok       = RW'(cmd_ff.buf_index) < MEM_EXT;
   assign out_of_range = (off_ext > MEM_EXT) || (len_ext > RW'(MEM_EXT - off_ext));
   assign misaligned   = ((off_ext & SEC_MASK) != '0) || ((len_ext & SEC_MASK) != '0);
   assign ticks_dec    = (ticks_ff == '0) ? '0 : LAT_W'(ticks_ff - LAT_W'(1));

   // Item decode and job state update
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      result_in = result_ff;
      kind_in   = kind_ff;
      joff_in   = joff_ff;
      jlen_in   = jlen_ff;
      ticks_in  = ticks_ff;
      viol_in   = viol_ff;
      range_in  = range_ff;
      rej_in    = rej_ff;
      acc_in    = acc_ff;
      rb_in     = rb_ff;
      eng_start = 1'b0;
      eng_cmd   = '{kind: JOB_FILL, offset: '0, length: '0};
      stage_we  = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            acc_in = 1'b0;
            rb_in  = '0;
            unique case (cmd_ff.op)
               OP_INIT: begin
                  acc_in    = 1'b1;
                  status_in = ST_IDLE;
                  result_in = RES_OK;
                  ticks_in  = '0;
                  if (status_ff == ST_UNINIT) begin
                     viol_in   = '0;
                     range_in  = '0;
                     rej_in    = '0;
                     eng_start = 1'b1;
                  end
               end
               OP_READ, OP_WRITE, OP_ERASE: begin
                  if ((status_ff != ST_IDLE) || (cmd_ff.length == '0)) begin
                     rej_in = CNT_W'(rej_ff + CNT_W'(1));
                  end else if (out_of_range) begin
                     range_in = CNT_W'(range_ff + CNT_W'(1));
                  end else if ((cmd_ff.op == OP_ERASE) && misaligned) begin
                     rej_in = CNT_W'(rej_ff + CNT_W'(1));
                  end else begin
                     acc_in    = 1'b1;
                     joff_in   = cmd_ff.offset;
                     jlen_in   = cmd_ff.length;
                     ticks_in  = lat_ff;
                     status_in = ST_BUSY;
                     result_in = RES_PENDING;
                     if (cmd_ff.op == OP_READ) begin
                        kind_in = JOB_READ;
                     end else if (cmd_ff.op == OP_WRITE) begin
                        kind_in = JOB_WRITE;
                     end else begin
                        kind_in = JOB_ERASE;
                     end
                  end
               end
               OP_STAGE: begin
                  stage_we = idx_ok;
               end
               OP_TICK: begin
                  if (status_ff == ST_BUSY) begin
                     ticks_in = ticks_dec;
                     if (ticks_dec == '0) begin
                        eng_start = 1'b1;
                        eng_cmd   = '{kind: kind_ff, offset: joff_ff, length: jlen_ff};
                     end
                  end
               end
               OP_FETCH: begin
                  if (idx_ok) begin
                     rb_in = buf_rdata;
                  end
               end
               OP_NOP: begin
               end
            endcase
            if (eng_start) begin
               state_in = S_RUN;
            end else if (slot_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_RUN: begin
            // walker finished: job leaves the busy state with its outcome
            if (eng_stat.done) begin
               status_in = ST_IDLE;
               if (eng_stat.fail) begin
                  result_in = RES_FAILED;
                  viol_in   = CNT_W'(viol_ff + CNT_W'(1));
               end else begin
                  result_in = RES_OK;
               end
               if (slot_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register handshake
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lat_ff       <= LAT_RESET;
         status_ff    <= ST_UNINIT;
         result_ff    <= RES_OK;
         ticks_ff     <= '0;
         viol_ff      <= '0;
         range_ff     <= '0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         result_ff    <= result_in;
         ticks_ff     <= ticks_in;
         viol_ff      <= viol_in;
         range_ff     <= range_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            lat_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data;
      end
      kind_ff <= kind_in;
      joff_ff <= joff_in;
      jlen_ff <= jlen_in;
      acc_ff  <= acc_in;
      rb_ff   <= rb_in;
      if (load) begin
         rsp_data_ff.accepted           <= acc_in;
         rsp_data_ff.status             <= status_in;
         rsp_data_ff.job_result         <= result_in;
         rsp_data_ff.read_byte          <= rb_in;
         rsp_data_ff.violation_count    <= viol_in;
         rsp_data_ff.out_of_range_count <= range_in;
         rsp_data_ff.rejected_count     <= rej_in;
      end
   end

   // Memories and job walker; fetch reads are issued from the incoming item
   fje_engine #(
      .MEM_BYTES (MEM_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (eng_start),
      .cmd        (eng_cmd),
      .stat       (eng_stat),
      .host_we    (stage_we),
      .host_waddr (AW'(cmd_ff.buf_index)),
      .host_wdata (cmd_ff.data_byte),
      .host_raddr (AW'(req_data.buf_index)),
      .host_rdata (buf_rdata)
   );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the flash job emulator: directed table, then random job scripts.
module testbench;
   import fje_pkg::*;

   localparam int MEM_SIZE    = 16384;
   localparam int SECTOR_SIZE = 8192;
   // limit must exceed the longest walk, a full-size write with its verify and program passes
   localparam int QUIET_LIMIT = 200000;
   localparam int PHASE_ITEMS = 40;

   typedef enum logic [1:0] {PEND_NONE, PEND_READ, PEND_WRITE, PEND_ERASE} pend_kind_type;
   typedef enum logic [1:0] {CHK_OK, CHK_REJECT, CHK_RANGE} req_check_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LAT_W-1:0] csr_data  = '0;

   flash_job_emulator_top #(
      .MEM_BYTES    (MEM_SIZE),
      .SECTOR_BYTES (SECTOR_SIZE)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the emulator state
   logic [7:0]       flash_mem [0:MEM_SIZE-1];
   logic [7:0]       jbuf [0:MEM_SIZE-1];
   bit               jbuf_known [0:MEM_SIZE-1];
   int               known_list [$];
   int               known_prefix = 0;
   bit               flash_ready = 1'b0;
   status_type       m_status = ST_UNINIT;
   result_type       m_result = RES_OK;
   pend_kind_type    m_pend = PEND_NONE;
   logic [OFF_W-1:0] m_job_off = '0;
   logic [LEN_W-1:0] m_job_len = '0;
   logic [LAT_W-1:0] m_ticks = '0;
   logic [LAT_W-1:0] m_latency = LAT_RESET;
   logic [CNT_W-1:0] n_viol = '0;
   logic [CNT_W-1:0] n_range = '0;
   logic [CNT_W-1:0] n_rej = '0;

   rsp_type          flash_rsp_due [$];
   int               fail_count = 0;
   int               items_sent = 0;
   bit               burst_mode = 1'b0;

   // Receiver bookkeeping
   int               rsp_seen = 0;
   int               hold_left = 0;
   int               calm_left = 0;
   int               hold_mark = 0;
   int               quiet_cycles = 0;

   function automatic req_type mk_req(op_type op, logic [OFF_W-1:0] off,
                                      logic [LEN_W-1:0] len, logic [IDX_W-1:0] bi,
                                      logic [BYTE_W-1:0] db);
      req_type it;
      it.op        = op;
      it.offset    = off;
      it.length    = len;
      it.buf_index = bi;
      it.data_byte = db;
      return it;
   endfunction

   function automatic rsp_type mk_rsp(logic acc, status_type st, result_type res,
                                      logic [7:0] rb, logic [31:0] v, logic [31:0] r,
                                      logic [31:0] j);
      rsp_type o;
      o.accepted           = acc;
      o.status             = st;
      o.job_result         = res;
      o.read_byte          = rb;
      o.violation_count    = v;
      o.out_of_range_count = r;
      o.rejected_count     = j;
      return o;
   endfunction

   function automatic void mark_known(int idx);
      if (!jbuf_known[idx]) begin
         jbuf_known[idx] = 1'b1;
         known_list.push_back(idx);
      end
      while (known_prefix < MEM_SIZE && jbuf_known[known_prefix])
         known_prefix++;
   endfunction

   // Ordered admission checks: state and zero length, range, erase alignment
   function automatic req_check_type req_check(op_type op, logic [OFF_W-1:0] off,
                                               logic [LEN_W-1:0] len);
      int o;
      int l;
      o = off;
      l = len;
      if (!flash_ready || m_status == ST_BUSY || l == 0)
         return CHK_REJECT;
      if (o > MEM_SIZE || l > MEM_SIZE - o)
         return CHK_RANGE;
      if (op == OP_ERASE && ((o % SECTOR_SIZE) != 0 || (l % SECTOR_SIZE) != 0))
         return CHK_REJECT;
      return CHK_OK;
   endfunction

   // Job execution on the final tick
   function automatic void run_job();
      int i;
      int o;
      int l;
      o = m_job_off;
      l = m_job_len;
      case (m_pend)
         PEND_READ: begin
            for (i = 0; i < l; i++) begin
               jbuf[i] = flash_mem[o+i];
               mark_known(i);
            end
            m_result = RES_OK;
         end
         PEND_ERASE: begin
            for (i = 0; i < l; i++)
               flash_mem[o+i] = ERASED_BYTE;
            m_result = RES_OK;
         end
         PEND_WRITE: begin
            // any 0-to-1 bit fails the whole job, flash untouched
            for (i = 0; i < l; i++) begin
               if ((flash_mem[o+i] & jbuf[i]) != jbuf[i]) begin
                  n_viol++;
                  m_result = RES_FAILED;
                  return;
               end
            end
            for (i = 0; i < l; i++)
               flash_mem[o+i] = jbuf[i];
            m_result = RES_OK;
         end
         default: m_result = RES_FAILED;
      endcase
   endfunction

   function automatic void tick_step();
      if (m_status != ST_BUSY || m_pend == PEND_NONE)
         return;
      if (m_ticks > 0) begin
         m_ticks--;
         if (m_ticks > 0)
            return;
      end
      run_job();
      m_pend   = PEND_NONE;
      m_status = ST_IDLE;
   endfunction

   // Predicts the response to one item and advances the shadow state
   function automatic rsp_type flash_predict(req_type it);
      logic          acc;
      logic [7:0]    rb;
      req_check_type chk;
      int            i;
      acc = 1'b0;
      rb  = 8'h00;
      case (it.op)
         OP_INIT: begin
            if (!flash_ready) begin
               for (i = 0; i < MEM_SIZE; i++)
                  flash_mem[i] = ERASED_BYTE;
               n_viol      = '0;
               n_range     = '0;
               n_rej       = '0;
               flash_ready = 1'b1;
            end
            m_pend   = PEND_NONE;
            m_ticks  = '0;
            m_status = ST_IDLE;
            m_result = RES_OK;
            acc      = 1'b1;
         end
         OP_READ, OP_WRITE, OP_ERASE: begin
            chk = req_check(it.op, it.offset, it.length);
            if (chk == CHK_RANGE)
               n_range++;
            else if (chk == CHK_REJECT)
               n_rej++;
            else begin
               m_pend    = (it.op == OP_READ) ? PEND_READ :
                           (it.op == OP_WRITE) ? PEND_WRITE : PEND_ERASE;
               m_job_off = it.offset;
               m_job_len = it.length;
               m_ticks   = m_latency;
               m_status  = ST_BUSY;
               m_result  = RES_PENDING;
               acc       = 1'b1;
            end
         end
         OP_STAGE: begin
            jbuf[it.buf_index] = it.data_byte;
            mark_known(it.buf_index);
         end
         OP_TICK:  tick_step();
         OP_FETCH: rb = jbuf[it.buf_index];
         default: ;
      endcase
      return mk_rsp(acc, m_status, m_result, rb, n_viol, n_range, n_rej);
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 0;
      if (r < 75)
         return $urandom_range(1, 64);
      if (r < 85)
         return MEM_SIZE - $urandom_range(0, 2);
      return $urandom_range(1, MEM_SIZE);
   endfunction

   function automatic req_type noise_req();
      req_type it;
      int      r;
      r = $urandom_range(0, 99);
      it.op        = (r < 4) ? OP_INIT : (r < 8) ? OP_NOP : op_type'($urandom_range(1, 6));
      it.length    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767) : pick_len();
      r = $urandom_range(0, 99);
      if (r < 40)
         it.offset = $urandom_range(0, 32767);
      else if (r < 60 && it.length <= MEM_SIZE)
         it.offset = MEM_SIZE - it.length + $urandom_range(0, 1);
      else
         it.offset = $urandom_range(0, MEM_SIZE);
      it.buf_index = $urandom_range(0, MEM_SIZE - 1);
      it.data_byte = $urandom_range(0, 255);
      return it;
   endfunction

   // Keeps jobs mostly short and never reads a job buffer entry that was not written
   function automatic req_type tame(req_type it);
      req_type t;
      t = it;
      if ((t.op == OP_READ || t.op == OP_WRITE) && req_check(t.op, t.offset, t.length) == CHK_OK
          && t.length > 256 && $urandom_range(0, 9) != 0)
         t.length = $urandom_range(1, 64);
      if (t.op == OP_WRITE && req_check(t.op, t.offset, t.length) == CHK_OK
          && t.length > known_prefix) begin
         if (known_prefix > 0)
            t.length = $urandom_range(1, known_prefix);
         else
            t.op = OP_STAGE;
      end
      if (t.op == OP_FETCH && !jbuf_known[t.buf_index]) begin
         if (known_list.size() > 0)
            t.buf_index = known_list[$urandom_range(0, known_list.size() - 1)];
         else
            t.op = OP_STAGE;
      end
      return t;
   endfunction

   // Predict, queue the expected response, then offer the item until taken
   task automatic issue(req_type it, bit typed, rsp_type want);
      rsp_type pred;
      int      gap;
      pred = flash_predict(it);
      flash_rsp_due.push_back(typed ? want : pred);
      if (it.op != OP_NOP)
         items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (flash_rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_latency(logic [LAT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      m_latency = v;
   endtask

   // One well-formed job: optional init, staging, request, ticks, fetches
   task automatic job_script();
      op_type     kind;
      int         n;
      int         off;
      int         i;
      int         r;
      int         waits;
      bit         spoil;
      bit         cancel;
      logic [7:0] val;
      if (!flash_ready || $urandom_range(0, 19) == 0)
         issue(mk_req(OP_INIT, $urandom, $urandom, $urandom, $urandom), 0, '0);
      r = $urandom_range(0, 99);
      kind = (r < 45) ? OP_WRITE : (r < 90) ? OP_READ : OP_ERASE;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 2048) : $urandom_range(1, 32);
      if (kind == OP_ERASE) begin
         off = $urandom_range(0, 1) * SECTOR_SIZE;
         n   = (off == 0 && $urandom_range(0, 1) == 1) ? MEM_SIZE : SECTOR_SIZE;
      end else
         off = $urandom_range(0, MEM_SIZE - n);
      if (kind == OP_WRITE) begin
         // mostly 1-to-0 programming; sometimes random bytes that likely violate
         spoil = ($urandom_range(0, 5) == 0);
         for (i = 0; i < n && i < 32; i++) begin
            val = spoil ? $urandom_range(0, 255) : flash_mem[off+i] & $urandom_range(0, 255);
            issue(mk_req(OP_STAGE, $urandom, $urandom, i, val), 0, '0);
         end
      end
      issue(tame(mk_req(kind, off, n, $urandom, $urandom)), 0, '0);
      // traffic while the job is pending
      if ($urandom_range(0, 3) == 0)
         issue(tame(noise_req()), 0, '0);
      waits  = (m_latency == 0) ? 1 : m_latency;
      cancel = ($urandom_range(0, 11) == 0);
      waits  = cancel ? $urandom_range(0, waits - 1) : waits + $urandom_range(0, 2);
      for (i = 0; i < waits; i++)
         issue(mk_req(OP_TICK, $urandom, $urandom, $urandom, $urandom), 0, '0);
      if (cancel)
         issue(mk_req(OP_INIT, $urandom, $urandom, $urandom, $urandom), 0, '0);
      if (kind == OP_READ) begin
         r = $urandom_range(1, 6);
         for (i = 0; i < r; i++)
            issue(tame(mk_req(OP_FETCH, $urandom, $urandom, $urandom_range(0, n - 1),
                              $urandom)), 0, '0);
      end
   endtask

   task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_rsp(rsp_type want, rsp_type got);
      field_check("accepted", want.accepted, got.accepted);
      field_check("status", want.status, got.status);
      field_check("job_result", want.job_result, got.job_result);
      field_check("read_byte", want.read_byte, got.read_byte);
      field_check("violation_count", want.violation_count, got.violation_count);
      field_check("out_of_range_count", want.out_of_range_count, got.out_of_range_count);
      field_check("rejected_count", want.rejected_count, got.rejected_count);
   endtask

   // Response side: check accepted items, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (flash_rsp_due.size() == 0) begin
            $error("response item arrived with nothing expected");
            fail_count++;
         end else
            check_rsp(flash_rsp_due.pop_front(), rsp_data);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_mark < 2 && rsp_seen >= ((hold_mark == 0) ? 90 : 330)) begin
         // long hold-off so the block backs up and stalls its input
         rsp_stall <= 1'b1;
         hold_left = 150;
         hold_mark++;
      end else if (calm_left > 0) begin
         rsp_stall <= 1'b0;
         calm_left--;
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               rsp_stall <= 1'b0;
               calm_left = $urandom_range(20, 80);
            end
            1, 2, 3, 4, 5: rsp_stall <= 1'b0;
            6, 7, 8: begin
               rsp_stall <= 1'b1;
               hold_left = $urandom_range(0, 2);
            end
            default: begin
               rsp_stall <= 1'b1;
               hold_left = $urandom_range(5, 30);
            end
         endcase
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** flash_job_emulator_top: FAILED **");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      req_type          dir_items [$];
      bit               dir_typed [$];
      rsp_type          dir_want [$];
      logic [LAT_W-1:0] lat_plan [5];
      int               p;
      int               i;
      int               phase_start;

      lat_plan = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd2};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_latency(LAT_RESET);

      // Directed table; typed responses where they are obvious
      dir_items.push_back(mk_req(OP_READ, 0, 1, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_UNINIT, RES_OK, 8'h00, 0, 0, 1));
      dir_items.push_back(mk_req(OP_TICK, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_UNINIT, RES_OK, 8'h00, 0, 0, 1));
      dir_items.push_back(mk_req(OP_NOP, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_UNINIT, RES_OK, 8'h00, 0, 0, 1));
      dir_items.push_back(mk_req(OP_INIT, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(1, ST_IDLE, RES_OK, 8'h00, 0, 0, 0));
      // zero length, offset at end, offset past end, misaligned erase, huge length
      dir_items.push_back(mk_req(OP_READ, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'h00, 0, 0, 1));
      dir_items.push_back(mk_req(OP_READ, MEM_SIZE, 1, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'h00, 0, 1, 1));
      dir_items.push_back(mk_req(OP_READ, 15'h7FFF, 1, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'h00, 0, 2, 1));
      dir_items.push_back(mk_req(OP_ERASE, 100, SECTOR_SIZE, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'h00, 0, 2, 2));
      dir_items.push_back(mk_req(OP_WRITE, 0, 15'h7FFF, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'h00, 0, 3, 2));
      dir_items.push_back(mk_req(OP_STAGE, 0, 0, 0, 8'h00)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_STAGE, 0, 0, 14'h3FFF, 8'hFF)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_FETCH, 0, 0, 14'h3FFF, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'hFF, 0, 3, 2));
      // program the last byte to 0x00, rejected request while busy
      dir_items.push_back(mk_req(OP_WRITE, MEM_SIZE - 1, 1, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(1, ST_BUSY, RES_PENDING, 8'h00, 0, 3, 2));
      dir_items.push_back(mk_req(OP_READ, 0, 1, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_BUSY, RES_PENDING, 8'h00, 0, 3, 3));
      dir_items.push_back(mk_req(OP_TICK, 0, 0, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_READ, MEM_SIZE - 1, 1, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_TICK, 0, 0, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_FETCH, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_OK, 8'h00, 0, 3, 3));
      // 0-to-1 write fails and counts a violation
      dir_items.push_back(mk_req(OP_STAGE, 0, 0, 0, 8'hFF)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_WRITE, MEM_SIZE - 1, 1, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_TICK, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(0, ST_IDLE, RES_FAILED, 8'h00, 1, 3, 3));
      // aligned erase of the upper sector, second init keeps counters
      dir_items.push_back(mk_req(OP_ERASE, SECTOR_SIZE, SECTOR_SIZE, 0, 0));
      dir_typed.push_back(0); dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_TICK, 0, 0, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_INIT, 0, 0, 0, 0)); dir_typed.push_back(1);
      dir_want.push_back(mk_rsp(1, ST_IDLE, RES_OK, 8'h00, 1, 3, 3));
      // full-size read fills the whole job buffer
      dir_items.push_back(mk_req(OP_READ, 0, MEM_SIZE, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_TICK, 0, 0, 0, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);
      dir_items.push_back(mk_req(OP_FETCH, 0, 0, 14'h3FFF, 0)); dir_typed.push_back(0);
      dir_want.push_back('0);

      for (i = 0; i < dir_items.size(); i++)
         issue(dir_items[i], dir_typed[i], dir_want[i]);

      // Random phases, one latency setting each
      for (p = 0; p < 5; p++) begin
         drain();
         set_latency(lat_plan[p]);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
               job_script();
            else
               issue(tame(noise_req()), 0, '0);
            if ($urandom_range(0, 49) == 0)
               drain();
         end
      end

      req_valid <= 1'b0;
      while (flash_rsp_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("** flash_job_emulator_top: PASSED **");
      else
         $display("** flash_job_emulator_top: FAILED **");
      $finish;
   end

endmodule

FILE: flash_job_emulator_top.f
src/fje_pkg.sv
src/fje_engine.sv
src/flash_job_emulator_top.sv
tb/testbench.sv
